// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is high.
`define CRSB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check, also evaluated during reset.
`define CRSB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/crsb_pkg.sv =====
// Types and constants for the clipped run-length sprite blitter.
package crsb_pkg;

  localparam int ADDR_WIDTH_DEF = 32;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  localparam logic [15:0] STRIDE_RESET = 16'd320;

  typedef enum logic [1:0] {
    PH_SKIP = 2'd0,
    PH_DRAW = 2'd1,
    PH_PIX  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PIXEL      = 2'd0,
    KIND_ROW_END    = 2'd1,
    KIND_SPRITE_END = 2'd2
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CLIP_X        = 4'd0,
    REG_CLIP_WIDTH    = 4'd1,
    REG_ROW_COUNT     = 4'd2,
    REG_SCREEN_STRIDE = 4'd3
  } reg_index_t;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [14:0] clip_x;
    logic [14:0] clip_width;
    logic [15:0] row_count;
    logic [15:0] screen_stride;
  } cfg_t;

  // Result fields other than the destination offset.
  typedef struct packed {
    kind_t       kind;
    logic [14:0] column;
    logic [15:0] row;
    logic [15:0] pixel;
  } res_t;

endpackage

// ===== rtl/crsb_step.sv =====
// Run-stream decoder: phase, position and row state plus clip test for one word.
module crsb_step #(
  parameter int ADDR_WIDTH = crsb_pkg::ADDR_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  crsb_pkg::cfg_t        cfg,
  input  logic                  accept,
  input  logic [15:0]           rle_word,
  output logic                  push,
  output crsb_pkg::res_t        res,
  output logic [ADDR_WIDTH-1:0] dest
);
  import crsb_pkg::*;

  phase_t                phase;
  logic [15:0]           x_pos;
  logic [15:0]           pixels_left;
  logic [15:0]           row_index;
  logic [ADDR_WIDTH-1:0] row_base;

  phase_t                phase_next;
  logic [15:0]           x_pos_next;
  logic [15:0]           pixels_left_next;
  logic [15:0]           row_index_next;
  logic [ADDR_WIDTH-1:0] row_base_next;

  logic [15:0] clip_hi;
  logic        visible;
  logic [14:0] col;
  logic        last_row;
  logic [15:0] left_dec;

  always_comb begin
    clip_hi  = {1'b0, cfg.clip_x} + {1'b0, cfg.clip_width};
    visible  = !x_pos[15] && (x_pos[14:0] >= cfg.clip_x) && (x_pos < clip_hi);
    col      = x_pos[14:0] - cfg.clip_x;
    last_row = ({1'b0, row_index} + 17'd1) >= {1'b0, cfg.row_count};
    left_dec = pixels_left - 16'd1;

    phase_next       = phase;
    x_pos_next       = x_pos;
    pixels_left_next = pixels_left;
    row_index_next   = row_index;
    row_base_next    = row_base;
    push             = 1'b0;
    res.kind         = KIND_PIXEL;
    res.column       = '0;
    res.row          = row_index;
    res.pixel        = '0;
    dest             = row_base;

    case (phase)
      PH_DRAW: begin
        if (rle_word != 16'd0) begin
          pixels_left_next = rle_word;
          phase_next       = PH_PIX;
        end else begin
          // draw count of zero closes the line
          push             = 1'b1;
          phase_next       = PH_SKIP;
          x_pos_next       = '0;
          pixels_left_next = '0;
          if (last_row) begin
            res.kind       = KIND_SPRITE_END;
            row_index_next = '0;
            row_base_next  = '0;
          end else begin
            res.kind       = KIND_ROW_END;
            row_index_next = row_index + 16'd1;
            row_base_next  = row_base + ADDR_WIDTH'(cfg.screen_stride);
          end
        end
      end
      PH_PIX: begin
        push             = visible;
        res.column       = col;
        res.pixel        = rle_word;
        dest             = row_base + ADDR_WIDTH'(col);
        x_pos_next       = x_pos + 16'd1;
        pixels_left_next = left_dec;
        if (left_dec == 16'd0) begin
          phase_next = PH_SKIP;
        end
      end
      default: begin
        // skip count; the unused phase code lands here as well
        x_pos_next = x_pos + rle_word;
        phase_next = PH_DRAW;
      end
    endcase

    push = push && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SKIP;
      x_pos       <= '0;
      pixels_left <= '0;
      row_index   <= '0;
      row_base    <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      x_pos       <= x_pos_next;
      pixels_left <= pixels_left_next;
      row_index   <= row_index_next;
      row_base    <= row_base_next;
    end
  end

endmodule

// ===== rtl/crsb_outbuf.sv =====
// Result register with one skid entry that takes one result on a stall before the input side stops.
module crsb_outbuf #(
  parameter int ADDR_WIDTH = crsb_pkg::ADDR_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  crsb_pkg::res_t        push_res,
  input  logic [ADDR_WIDTH-1:0] push_dest,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output crsb_pkg::res_t        out_res,
  output logic [ADDR_WIDTH-1:0] out_dest
);
  import crsb_pkg::*;

  logic                  skid_valid;
  res_t                  skid_res;
  logic [ADDR_WIDTH-1:0] skid_dest;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_res  <= skid_res;
        out_dest <= skid_dest;
      end else begin
        out_res  <= push_res;
        out_dest <= push_dest;
      end
    end else if (push) begin
      skid_res  <= push_res;
      skid_dest <= push_dest;
    end
  end

endmodule

// ===== rtl/clipped_run_sprite_blitter.sv =====
// Top level of the clipped run-length sprite blitter.
//
// Input channel rle_valid/rle_ready/rle_word carries the run stream, one
// 16-bit word per transaction: skip count, draw count, then the pixel words.
// Result channel res_valid/res_ready carries kind, dest_offset, column, row
// and pixel: a pixel write for each visible pixel, and for a zero draw count
// a row-end marker, or a sprite-end marker instead at the end of line row_count.
// Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes
// clip_x (0), clip_width (1), row_count (2) and screen_stride (3); cfg_ready
// is always high, and writes are meant to land while the block is idle.
// Throughput: one word per cycle while rle_ready is high. A result is
// registered in the output register as the word that causes it is taken, or
// in the skid entry while the output is stalled.
// Stall: the output register has one skid entry behind it; rle_ready falls
// only while that entry is occupied, and rises again once the receiver takes
// a result.
// Reset (rst, synchronous) empties the output, returns to the start of a row
// at row 0, and loads the register defaults (stride 320, the rest zero).
`include "assert_macros.svh"

module clipped_run_sprite_blitter #(
  parameter int ADDR_WIDTH = crsb_pkg::ADDR_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             rle_valid,
  output logic                             rle_ready,
  input  logic [15:0]                      rle_word,
  output logic                             res_valid,
  input  logic                             res_ready,
  output crsb_pkg::kind_t                  kind,
  output logic [ADDR_WIDTH-1:0]            dest_offset,
  output logic [14:0]                      column,
  output logic [15:0]                      row,
  output logic [15:0]                      pixel,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [crsb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [crsb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import crsb_pkg::*;

  cfg_t                  cfg;
  logic                  accept;
  logic                  push;
  res_t                  push_res;
  logic [ADDR_WIDTH-1:0] push_dest;
  res_t                  out_res;

  assign cfg_ready = 1'b1;
  assign accept    = rle_valid && rle_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clip_x        <= '0;
      cfg.clip_width    <= '0;
      cfg.row_count     <= '0;
      cfg.screen_stride <= STRIDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CLIP_X:        cfg.clip_x        <= cfg_data[14:0];
        REG_CLIP_WIDTH:    cfg.clip_width    <= cfg_data[14:0];
        REG_ROW_COUNT:     cfg.row_count     <= cfg_data;
        REG_SCREEN_STRIDE: cfg.screen_stride <= cfg_data;
        default: ;
      endcase
    end
  end

  crsb_step #(.ADDR_WIDTH(ADDR_WIDTH)) u_step (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .accept   (accept),
    .rle_word (rle_word),
    .push     (push),
    .res      (push_res),
    .dest     (push_dest)
  );

  crsb_outbuf #(.ADDR_WIDTH(ADDR_WIDTH)) u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_res  (push_res),
    .push_dest (push_dest),
    .in_ready  (rle_ready),
    .out_valid (res_valid),
    .out_ready (res_ready),
    .out_res   (out_res),
    .out_dest  (dest_offset)
  );

  assign kind   = out_res.kind;
  assign column = out_res.column;
  assign row    = out_res.row;
  assign pixel  = out_res.pixel;

  // input side only blocks while a result is waiting to go out
  `CRSB_ASSERT_ALWAYS(a_ready_only_stalled, clk, !rle_ready |-> res_valid, "input stalled with output empty")
  // visible pixels always fall inside the window
  `CRSB_ASSERT(a_col_in_window, clk, rst, (res_valid && kind == KIND_PIXEL) |-> ({1'b0, column} < {1'b0, cfg.clip_width}), "pixel column outside clip window")
  // markers carry no column and no pixel
  `CRSB_ASSERT(a_marker_clean, clk, rst, (res_valid && kind != KIND_PIXEL) |-> (column == '0 && pixel == '0), "row marker with pixel data")

endmodule
